### sv/cm3e_pkg.sv
// Package for the 3x3 complex matrix exponential block.
// Holds the number format constants and the reciprocal factorial table.
`timescale 1ns / 1ps
package cm3e_pkg;
  localparam int Dim      = 3;
  localparam int MaxTerms = 12;
  localparam int FracBits = 16;
  localparam int RecipLast = 12;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // 1/n! with 31 fraction bits, rounded to nearest.
  function automatic logic [31:0] recip_fact(input logic [3:0] n);
    logic [31:0] r;
    begin
      case (n)
        4'd0:    r = 32'd2147483648;
        4'd1:    r = 32'd2147483648;
        4'd2:    r = 32'd1073741824;
        4'd3:    r = 32'd357913941;
        4'd4:    r = 32'd89478485;
        4'd5:    r = 32'd17895697;
        4'd6:    r = 32'd2982616;
        4'd7:    r = 32'd426088;
        4'd8:    r = 32'd53261;
        4'd9:    r = 32'd5918;
        4'd10:   r = 32'd592;
        4'd11:   r = 32'd54;
        4'd12:   r = 32'd4;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    begin
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction
endpackage

### sv/complex_matrix3_exp_taylor.sv
// Top level: 3x3 complex matrix exponential by truncated Taylor series.
// Busy stays high through a compute transaction, whose term count N is clamped to 12.
// Each term after the first takes a matrix product, then a scaling, on the one shared multiplier.
// Loads hold busy for one cycle. Results come nine per compute and cannot be stalled.
// rst_ni clears most registers but not memories; the matrix store is undefined until loaded.
`timescale 1ns / 1ps
module complex_matrix3_exp_taylor #(
  parameter int Dim      = cm3e_pkg::Dim,
  parameter int MaxTerms = cm3e_pkg::MaxTerms,
  parameter int FracBits = cm3e_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [1:0]         row_i,
  input  logic [1:0]         col_i,
  input  logic signed [31:0] elem_real_i,
  input  logic signed [31:0] elem_imag_i,
  input  logic [3:0]         term_count_i,
  output logic               strobe,
  output logic [1:0]         out_row_o,
  output logic [1:0]         out_col_o,
  output logic signed [31:0] out_real_o,
  output logic signed [31:0] out_imag_o,
  output logic               last_o
);
  localparam int Cells = Dim * Dim;
  localparam int CW    = $clog2(Cells);
  localparam int KW    = $clog2(Dim);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_INIT, S_MRD, S_MWAIT, S_MCAP, S_MACC, S_MWR,
    S_SRD, S_SWAIT, S_SMUL, S_SCAP, S_SWR, S_ORD, S_OUT
  } state_e;

  typedef logic signed [63:0] cplx_t;  // {real, imag}

  // Memories: A, power, next power and sum, each complex.
  cplx_t mat_mem [Cells];
  cplx_t pow_mem [Cells];
  cplx_t nxt_mem [Cells];
  cplx_t sum_mem [Cells];

  state_e state_q;
  logic [3:0] n_q, terms_q;
  logic [KW-1:0] i_q, j_q, k_q;
  logic [CW-1:0] c_q;
  logic [2:0] ph_q;
  logic signed [49:0] accr_q, acci_q;
  cplx_t pa_q, mb_q, sm_q, pw_q;
  logic signed [31:0] tr_q;
  logic [CW-1:0] ld_addr_q;
  cplx_t ld_data_q;
  logic ld_ok_q;

  logic signed [31:0] mac_a;
  logic signed [32:0] mac_b;
  logic mac_scale;
  logic signed [47:0] mac_p;

  cm3e_mac #(.FracBits(FracBits)) u_mac (
    .clk_i(clk_i), .a_i(mac_a), .b_i(mac_b), .scale_i(mac_scale), .p_o(mac_p)
  );

  // In matrix states phases 0..3 issue ac, bd, ad, bc; each result arrives in the next cycle.
  always_comb begin
    mac_scale = 1'b0;
    mac_a = pa_q[63:32];
    mac_b = 33'($signed(mb_q[63:32]));
    if (state_q == S_SMUL || state_q == S_SCAP) begin
      mac_scale = 1'b1;
      mac_a = (ph_q == 3'd0) ? pw_q[63:32] : pw_q[31:0];
      mac_b = $signed({1'b0, cm3e_pkg::recip_fact(n_q)});
    end else begin
      case (ph_q)
        3'd0: begin mac_a = pa_q[63:32]; mac_b = 33'($signed(mb_q[63:32])); end
        3'd1: begin mac_a = pa_q[31:0];  mac_b = 33'($signed(mb_q[31:0]));  end
        3'd2: begin mac_a = pa_q[63:32]; mac_b = 33'($signed(mb_q[31:0]));  end
        default: begin mac_a = pa_q[31:0]; mac_b = 33'($signed(mb_q[63:32])); end
      endcase
    end
  end

  logic [CW-1:0] pa_addr, mb_addr, ij_addr;
  assign pa_addr = CW'(i_q * Dim + k_q);
  assign mb_addr = CW'(k_q * Dim + j_q);
  assign ij_addr = CW'(i_q * Dim + j_q);

  // Row and column of c_q, found by comparing against the start of each row.
  logic [CW-1:0] c_row, c_col;
  always_comb begin
    c_row = '0;
    for (int r = 1; r < Dim; r++) begin
      if (32'(c_q) >= r * Dim) c_row = CW'(r);
    end
    c_col = c_q - CW'(32'(c_row) * Dim);
  end

  // Memory ports, each read registered.
  logic pw_we, nx_we, sm_we, mt_we;
  logic [CW-1:0] pw_wa, nx_wa, sm_wa, mt_wa;
  cplx_t pw_wd, nx_wd, sm_wd, mt_wd;
  logic [CW-1:0] pr_ra, nx_ra, sm_ra, mt_ra;
  cplx_t pr_rd, nx_rd, sm_rd, mt_rd;

  always_ff @(posedge clk_i) begin
    if (mt_we) mat_mem[mt_wa] <= mt_wd;
    if (pw_we) pow_mem[pw_wa] <= pw_wd;
    if (nx_we) nxt_mem[nx_wa] <= nx_wd;
    if (sm_we) sum_mem[sm_wa] <= sm_wd;
    mt_rd <= mat_mem[mt_ra];
    pr_rd <= pow_mem[pr_ra];
    nx_rd <= nxt_mem[nx_ra];
    sm_rd <= sum_mem[sm_ra];
  end

  logic signed [31:0] one_fx;
  assign one_fx = 32'sd1 <<< FracBits;
  logic signed [49:0] sr_new;
  assign sr_new = 50'($signed(sm_q[63:32])) + 50'(tr_q);
  logic signed [49:0] si_new;
  assign si_new = 50'($signed(sm_q[31:0])) + 50'(mac_p);

  always_comb begin
    mt_we = (state_q == S_LOAD) && ld_ok_q;
    mt_wa = ld_addr_q;
    mt_wd = ld_data_q;
    pw_we = 1'b0; pw_wa = c_q; pw_wd = '0;
    nx_we = 1'b0; nx_wa = ij_addr;
    nx_wd = {cm3e_pkg::sat32(accr_q), cm3e_pkg::sat32(acci_q)};
    sm_we = 1'b0; sm_wa = c_q;
    sm_wd = {cm3e_pkg::sat32(sr_new), cm3e_pkg::sat32(si_new)};
    pr_ra = pa_addr; mt_ra = mb_addr; nx_ra = c_q; sm_ra = c_q;
    case (state_q)
      S_INIT: begin
        pw_we = 1'b1;
        pw_wd = {(c_row == c_col) ? one_fx : 32'sd0, 32'sd0};
        sm_we = 1'b1; sm_wd = '0;
      end
      S_MWR: nx_we = 1'b1;
      S_SRD: pr_ra = c_q;
      S_SWR: begin
        sm_we = 1'b1;
        // Copy the new power over once it has been consumed by scaling.
        pw_we = (n_q != 4'd0); pw_wd = pw_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy <= 1'b0; strobe <= 1'b0; last_o <= 1'b0;
      n_q <= '0; terms_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
      c_q <= '0; ph_q <= '0; ld_ok_q <= 1'b0;
      ld_addr_q <= '0; ld_data_q <= '0;
      accr_q <= '0; acci_q <= '0;
      pa_q <= '0; mb_q <= '0; sm_q <= '0; pw_q <= '0; tr_q <= '0;
      out_row_o <= '0; out_col_o <= '0; out_real_o <= '0; out_imag_o <= '0;
    end else begin
      strobe <= 1'b0;
      last_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            if (mode_i == cm3e_pkg::MODE_LOAD) begin
              ld_ok_q <= (32'(row_i) < Dim) && (32'(col_i) < Dim);
              ld_addr_q <= CW'(32'(row_i) * Dim + 32'(col_i));
              ld_data_q <= {elem_real_i, elem_imag_i};
              state_q <= S_LOAD;
            end else begin
              terms_q <= (32'(term_count_i) > MaxTerms) ? 4'(MaxTerms) : term_count_i;
              c_q <= '0; n_q <= '0;
              state_q <= S_INIT;
            end
          end
        end
        S_LOAD: begin
          busy <= 1'b0; state_q <= S_IDLE;
        end
        S_INIT: begin
          if (32'(c_q) == Cells - 1) begin
            c_q <= '0; state_q <= S_SRD;
          end else c_q <= c_q + 1'b1;
        end
        S_MRD: begin
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          pa_q <= pr_rd; mb_q <= mt_rd; ph_q <= '0;
          if (k_q == '0) begin accr_q <= '0; acci_q <= '0; end
          state_q <= S_MCAP;
        end
        S_MCAP: begin
          // Issue four products, accumulate as they come back.
          if (ph_q != 3'd0) begin
            case (ph_q)
              3'd1: accr_q <= accr_q + 50'(mac_p);
              3'd2: accr_q <= accr_q - 50'(mac_p);
              3'd3: acci_q <= acci_q + 50'(mac_p);
              default: ;
            endcase
          end
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd3) state_q <= S_MACC;
        end
        S_MACC: begin
          acci_q <= acci_q + 50'(mac_p);
          if (32'(k_q) == Dim - 1) state_q <= S_MWR;
          else begin k_q <= k_q + 1'b1; state_q <= S_MRD; end
        end
        S_MWR: begin
          k_q <= '0;
          if (32'(j_q) == Dim - 1) begin
            j_q <= '0;
            if (32'(i_q) == Dim - 1) begin
              i_q <= '0; c_q <= '0; state_q <= S_SRD;
            end else i_q <= i_q + 1'b1;
          end else j_q <= j_q + 1'b1;
          if (!(32'(j_q) == Dim - 1 && 32'(i_q) == Dim - 1)) state_q <= S_MRD;
        end
        S_SRD: state_q <= S_SWAIT;
        S_SWAIT: begin
          pw_q <= (n_q == 4'd0) ? pr_rd : nx_rd;
          sm_q <= sm_rd; ph_q <= '0;
          state_q <= S_SMUL;
        end
        S_SMUL: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd1) begin
            tr_q <= mac_p[31:0];
            state_q <= S_SCAP;
          end
        end
        S_SCAP: begin
          state_q <= S_SWR;
        end
        S_SWR: begin
          if (32'(c_q) == Cells - 1) begin
            c_q <= '0;
            if (n_q == terms_q) state_q <= S_ORD;
            else begin n_q <= n_q + 1'b1; state_q <= S_MRD; end
          end else begin
            c_q <= c_q + 1'b1; state_q <= S_SRD;
          end
        end
        S_ORD: state_q <= S_OUT;
        S_OUT: begin
          strobe <= 1'b1;
          out_row_o <= c_row[1:0];
          out_col_o <= c_col[1:0];
          out_real_o <= sm_rd[63:32];
          out_imag_o <= sm_rd[31:0];
          last_o <= (32'(c_q) == Cells - 1);
          if (32'(c_q) == Cells - 1) begin
            busy <= 1'b0; state_q <= S_IDLE;
          end else begin
            c_q <= c_q + 1'b1; state_q <= S_ORD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The real scale comes back in S_SMUL at ph_q 1 and is held in tr_q. The imaginary
  // operand stays on the multiplier through S_SCAP, so mac_p holds its scale in S_SWR.

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe) else $error("last without strobe");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(busy)) else $error("result while idle");
  a_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (32'(terms_q) <= MaxTerms)) else $error("term count out of range");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !busy) else $error("busy in idle");
endmodule

### sv/cm3e_mac.sv
// Shared signed 32x33 multiplier with rounding, registered output.
// Depends on cm3e_pkg. Rounds at a selectable shift, ties upward.
`timescale 1ns / 1ps
module cm3e_mac #(
  parameter int FracBits = cm3e_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic               scale_i,
  output logic signed [47:0] p_o
);
  logic signed [64:0] prod;
  logic signed [64:0] rnd;
  logic signed [47:0] p_d;

  always_comb begin
    prod = 65'(a_i) * 65'(b_i);
    if (scale_i) begin
      rnd = (prod + (65'sd1 <<< 30)) >>> 31;
    end else begin
      rnd = (prod + (65'sd1 <<< (FracBits - 1))) >>> FracBits;
    end
    // Scaled values always fit; raw products are clipped only far past saturation.
    if (rnd > 65'sh7fffffffffff) p_d = 48'sh7fffffffffff;
    else if (rnd < -65'sh800000000000) p_d = 48'sh800000000000;
    else p_d = rnd[47:0];
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end
endmodule
